FILE: src/sspb_pkg.sv
// Shared types, widths and constants of the scaled sprite pixel blitter.
`default_nettype none

package sspb_pkg;

  // Request opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPRITE_LEFT    = 3'd0,
    CFG_SPRITE_TOP     = 3'd1,
    CFG_SPRITE_SIZE    = 3'd2,
    CFG_SPRITE_DEPTH   = 3'd3,
    CFG_TEXTURE_WIDTH  = 3'd4,
    CFG_TEXTURE_HEIGHT = 3'd5
  } cfg_reg_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Field widths
  localparam int PIX_W    = 10;  // screen coordinate of a request
  localparam int POS_W    = 13;  // signed sprite corner
  localparam int SIZE_W   = 12;  // sprite side in pixels
  localparam int DEPTH_W  = 16;  // Q8.8 depth code
  localparam int TEXDIM_W = 7;   // texture width / height
  localparam int TIDX_W   = 12;  // texel index of a load
  localparam int TEXEL_W  = 32;  // texel color word

  // Screen size and the width used to compare coordinates against it
  localparam int SCREEN_W = 1024;
  localparam int SCREEN_H = 1024;
  localparam int SCR_W    = 13;

  // Datapath widths
  localparam int OFS_W      = SIZE_W;              // offset inside the sprite box
  localparam int DIFF_W     = POS_W + 1;           // signed pixel minus corner
  localparam int NUM_W      = OFS_W + TEXDIM_W;    // offset times texture size
  localparam int QUO_W      = TEXDIM_W;            // texel coordinate
  localparam int DIV_STEPS  = QUO_W;               // one quotient bit per stage
  localparam int RAW_ADDR_W = 2 * TEXDIM_W;        // texel address before wrap
  localparam int MOD_W      = RAW_ADDR_W + 1;      // wrap arithmetic width

  // Fixed pipeline depth: clip, scale, divide, address, memory, output
  localparam int PIPE_FIXED = DIV_STEPS + 5;

  localparam logic [7:0] ALPHA_MASK = 8'hFF;

  // Sideband that travels with every request down the pipe
  typedef struct packed {
    logic                valid;
    logic                load;
    logic                hit;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [TIDX_W-1:0]   tex_index;
    logic [TEXEL_W-1:0]  tex_value;
  } sspb_side_t;

  // Conditional-subtract stages needed to wrap a raw address into the memory
  function automatic int wrap_steps(int words);
    int aw;
    aw = $clog2(words);
    return (aw > RAW_ADDR_W) ? 0 : RAW_ADDR_W - aw + 1;
  endfunction

endpackage

`default_nettype wire

FILE: src/sspb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module sspb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/sspb_front.sv
// Front stages: screen clip, depth test, sprite box test and texture scaling.
`default_nettype none

module sspb_front import sspb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_i,
  input  wire logic                 op_i,
  input  wire logic [TIDX_W-1:0]    texel_index_i,
  input  wire logic [TEXEL_W-1:0]   texel_value_i,
  input  wire logic [PIX_W-1:0]     pixel_x_i,
  input  wire logic [PIX_W-1:0]     pixel_y_i,
  input  wire logic [DEPTH_W-1:0]   column_depth_i,
  input  wire logic signed [POS_W-1:0] sprite_left_i,
  input  wire logic signed [POS_W-1:0] sprite_top_i,
  input  wire logic [SIZE_W-1:0]    sprite_size_i,
  input  wire logic [DEPTH_W-1:0]   sprite_depth_i,
  input  wire logic [TEXDIM_W-1:0]  texture_width_i,
  input  wire logic [TEXDIM_W-1:0]  texture_height_i,
  output sspb_side_t                side_o,
  output logic [NUM_W-1:0]          num_x_o,
  output logic [NUM_W-1:0]          num_y_o
);

  logic signed [DIFF_W-1:0] dx, dy, size_s;
  logic                     on_screen, nearer, in_x, in_y;
  sspb_side_t               side_a_d, side_a_q, side_b_q;
  logic [OFS_W-1:0]         ox_a_q, oy_a_q;
  logic [NUM_W-1:0]         num_x_b_q, num_y_b_q;

  // Offsets of the pixel from the sprite corner
  assign dx     = $signed({{(DIFF_W-PIX_W){1'b0}}, pixel_x_i}) - {sprite_left_i[POS_W-1], sprite_left_i};
  assign dy     = $signed({{(DIFF_W-PIX_W){1'b0}}, pixel_y_i}) - {sprite_top_i[POS_W-1], sprite_top_i};
  assign size_s = $signed({{(DIFF_W-SIZE_W){1'b0}}, sprite_size_i});

  // Coverage and depth tests
  assign on_screen = ({{(SCR_W-PIX_W){1'b0}}, pixel_x_i} < SCR_W'(SCREEN_W)) &&
                     ({{(SCR_W-PIX_W){1'b0}}, pixel_y_i} < SCR_W'(SCREEN_H));
  assign nearer    = sprite_depth_i < column_depth_i;
  assign in_x      = !dx[DIFF_W-1] && (dx < size_s);
  assign in_y      = !dy[DIFF_W-1] && (dy < size_s);

  always_comb begin
    side_a_d           = '0;
    side_a_d.valid     = req_i;
    side_a_d.load      = (op_i == OP_LOAD);
    side_a_d.hit       = (op_i == OP_DRAW) && on_screen && nearer && in_x && in_y;
    side_a_d.px        = pixel_x_i;
    side_a_d.py        = pixel_y_i;
    side_a_d.tex_index = texel_index_i;
    side_a_d.tex_value = texel_value_i;
  end

  // Advance the sideband through both front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '0;
      side_b_q <= '0;
    end else begin
      side_a_q <= side_a_d;
      side_b_q <= side_a_q;
    end
  end

  // Hold the box offsets, then scale them by the texture size
  always_ff @(posedge clk_i) begin
    ox_a_q    <= dx[OFS_W-1:0];
    oy_a_q    <= dy[OFS_W-1:0];
    num_x_b_q <= NUM_W'(ox_a_q) * NUM_W'(texture_width_i);
    num_y_b_q <= NUM_W'(oy_a_q) * NUM_W'(texture_height_i);
  end

  assign side_o  = side_b_q;
  assign num_x_o = num_x_b_q;
  assign num_y_o = num_y_b_q;

endmodule

`default_nettype wire

FILE: src/sspb_div.sv
// Pipelined restoring divider: both texture axes divided by the sprite size.
`default_nettype none

module sspb_div import sspb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SIZE_W-1:0] size_i,
  input  wire sspb_side_t        side_i,
  input  wire logic [NUM_W-1:0]  num_x_i,
  input  wire logic [NUM_W-1:0]  num_y_i,
  output sspb_side_t             side_o,
  output logic [QUO_W-1:0]       quot_x_o,
  output logic [QUO_W-1:0]       quot_y_o
);

  sspb_side_t       side_q [DIV_STEPS];
  logic [NUM_W-1:0] rx_q   [DIV_STEPS];
  logic [NUM_W-1:0] ry_q   [DIV_STEPS];
  logic [QUO_W-1:0] qx_q   [DIV_STEPS];
  logic [QUO_W-1:0] qy_q   [DIV_STEPS];

  // One quotient bit per stage, most significant first; the quotient is
  // below the texture size, so seven bits cover every case
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int K = DIV_STEPS - 1 - s;

    sspb_side_t       side_in;
    logic [NUM_W-1:0] rx_in, ry_in, dvs;
    logic [QUO_W-1:0] qx_in, qy_in;
    logic             ge_x, ge_y;

    if (s == 0) begin : g_first
      assign side_in = side_i;
      assign rx_in   = num_x_i;
      assign ry_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign side_in = side_q[s-1];
      assign rx_in   = rx_q[s-1];
      assign ry_in   = ry_q[s-1];
      assign qx_in   = qx_q[s-1];
      assign qy_in   = qy_q[s-1];
    end

    assign dvs  = NUM_W'(size_i) << K;
    assign ge_x = rx_in >= dvs;
    assign ge_y = ry_in >= dvs;

    // Advance the sideband
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk_i) begin
      rx_q[s] <= ge_x ? rx_in - dvs : rx_in;
      ry_q[s] <= ge_y ? ry_in - dvs : ry_in;
      qx_q[s] <= qx_in | (QUO_W'(ge_x) << K);
      qy_q[s] <= qy_in | (QUO_W'(ge_y) << K);
    end
  end

  assign side_o   = side_q[DIV_STEPS-1];
  assign quot_x_o = qx_q[DIV_STEPS-1];
  assign quot_y_o = qy_q[DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: src/sspb_addr.sv
// Texel address forming and wrap into the texture memory depth.
`default_nettype none

module sspb_addr import sspb_pkg::*; #(
  parameter int TEXEL_WORDS = 4096,
  localparam int ADDR_W = $clog2(TEXEL_WORDS)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [TEXDIM_W-1:0] texture_width_i,
  input  wire sspb_side_t          side_i,
  input  wire logic [QUO_W-1:0]    quot_x_i,
  input  wire logic [QUO_W-1:0]    quot_y_i,
  output sspb_side_t               side_o,
  output logic [ADDR_W-1:0]        addr_o
);

  localparam int MOD_STEPS = wrap_steps(TEXEL_WORDS);

  sspb_side_t       side_q [MOD_STEPS+1];
  logic [MOD_W-1:0] rem_q  [MOD_STEPS+1];
  logic [MOD_W-1:0] raw_d;

  // Pick the load index or the row-major texel address
  assign raw_d = side_i.load ? MOD_W'(side_i.tex_index)
                             : MOD_W'(quot_y_i) * MOD_W'(texture_width_i) + MOD_W'(quot_x_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= raw_d;
  end

  // Wrap by conditional subtraction of the depth, largest multiple first
  for (genvar s = 1; s <= MOD_STEPS; s++) begin : g_wrap
    localparam int K = MOD_STEPS - s;
    localparam logic [MOD_W-1:0] SUB = MOD_W'(TEXEL_WORDS << K);

    logic ge;
    assign ge = rem_q[s-1] >= SUB;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? rem_q[s-1] - SUB : rem_q[s-1];
    end
  end

  assign side_o = side_q[MOD_STEPS];
  assign addr_o = ADDR_W'(rem_q[MOD_STEPS]);

endmodule

`default_nettype wire

FILE: src/scaled_sprite_pixel_blitter.sv
// Top level of the scaled sprite pixel blitter: registers, pipe, texture memory, output.
//
// Takes one request per clock and never raises busy. Every request, load or
// draw, returns exactly one result on done_o after it passes the front stages,
// the seven-stage sprite-size divider, the address stage, the address wrap
// stages (three at the default 4096-word texture memory), the memory read and
// the output register, in that order. The result stands on the outputs for
// one cycle only and the receiver cannot hold it off. Loads and draws share
// the one pipe, so a draw sees every load accepted before it. A draw fetches
// its texel from the internal memory and writes the framebuffer
// (write_enable_o high) when the pixel is on screen, inside the sprite box,
// nearer than the column depth and the texel alpha is non-zero; other
// results carry zeros. The texture memory has no reset: draw only texels
// that were loaded. Change the configuration only while no request is in
// flight.
`default_nettype none

module scaled_sprite_pixel_blitter import sspb_pkg::*; #(
  parameter int TEXEL_WORDS = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  op_i,
  input  wire logic [TIDX_W-1:0]     texel_index_i,
  input  wire logic [TEXEL_W-1:0]    texel_value_i,
  input  wire logic [PIX_W-1:0]      pixel_x_i,
  input  wire logic [PIX_W-1:0]      pixel_y_i,
  input  wire logic [DEPTH_W-1:0]    column_depth_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic                       write_enable_o,
  output logic [PIX_W-1:0]           out_x_o,
  output logic [PIX_W-1:0]           out_y_o,
  output logic [TEXEL_W-1:0]         color_o
);

  localparam int ADDR_W = $clog2(TEXEL_WORDS);

  logic signed [POS_W-1:0] sprite_left_q, sprite_top_q;
  logic [SIZE_W-1:0]       sprite_size_q;
  logic [DEPTH_W-1:0]      sprite_depth_q;
  logic [TEXDIM_W-1:0]     texture_width_q, texture_height_q;

  logic                    req;
  sspb_side_t              side_front, side_div, side_addr;
  logic [NUM_W-1:0]        num_x, num_y;
  logic [QUO_W-1:0]        quot_x, quot_y;
  logic [ADDR_W-1:0]       tex_addr;
  logic [TEXEL_W-1:0]      tex_rdata;
  logic                    ram_we, ram_re;

  logic                    valid_r_q, hit_r_q;
  logic [PIX_W-1:0]        px_r_q, py_r_q;
  logic                    wr_d;
  logic                    done_q, wr_q;
  logic [PIX_W-1:0]        out_x_q, out_y_q;
  logic [TEXEL_W-1:0]      color_q;

  // The pipe never stalls
  assign busy = 1'b0;
  assign req  = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_left_q    <= '0;
      sprite_top_q     <= '0;
      sprite_size_q    <= SIZE_W'(1);
      sprite_depth_q   <= '0;
      texture_width_q  <= TEXDIM_W'(64);
      texture_height_q <= TEXDIM_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SPRITE_LEFT:    sprite_left_q    <= cfg_data_i[POS_W-1:0];
        CFG_SPRITE_TOP:     sprite_top_q     <= cfg_data_i[POS_W-1:0];
        CFG_SPRITE_SIZE:    sprite_size_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_SPRITE_DEPTH:   sprite_depth_q   <= cfg_data_i[DEPTH_W-1:0];
        CFG_TEXTURE_WIDTH:  texture_width_q  <= cfg_data_i[TEXDIM_W-1:0];
        CFG_TEXTURE_HEIGHT: texture_height_q <= cfg_data_i[TEXDIM_W-1:0];
        default: ;
      endcase
    end
  end

  sspb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .op_i             (op_i),
    .texel_index_i    (texel_index_i),
    .texel_value_i    (texel_value_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .column_depth_i   (column_depth_i),
    .sprite_left_i    (sprite_left_q),
    .sprite_top_i     (sprite_top_q),
    .sprite_size_i    (sprite_size_q),
    .sprite_depth_i   (sprite_depth_q),
    .texture_width_i  (texture_width_q),
    .texture_height_i (texture_height_q),
    .side_o           (side_front),
    .num_x_o          (num_x),
    .num_y_o          (num_y)
  );

  sspb_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .size_i   (sprite_size_q),
    .side_i   (side_front),
    .num_x_i  (num_x),
    .num_y_i  (num_y),
    .side_o   (side_div),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  sspb_addr #(
    .TEXEL_WORDS (TEXEL_WORDS)
  ) u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .texture_width_i (texture_width_q),
    .side_i          (side_div),
    .quot_x_i        (quot_x),
    .quot_y_i        (quot_y),
    .side_o          (side_addr),
    .addr_o          (tex_addr)
  );

  // Loads write the texture memory, covered draws read it
  assign ram_we = side_addr.valid && side_addr.load;
  assign ram_re = side_addr.valid && !side_addr.load && side_addr.hit;

  sspb_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (TEXEL_WORDS)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tex_addr),
    .wdata_i (side_addr.tex_value),
    .re_i    (ram_re),
    .raddr_i (tex_addr),
    .rdata_o (tex_rdata)
  );

  // Hold the request alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_r_q <= 1'b0;
    end else begin
      valid_r_q <= side_addr.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_r_q <= ram_re;
    px_r_q  <= side_addr.px;
    py_r_q  <= side_addr.py;
  end

  // Drop transparent texels, zero every field that is not a write
  assign wr_d = hit_r_q && ((tex_rdata[7:0] & ALPHA_MASK) != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      wr_q   <= 1'b0;
    end else begin
      done_q <= valid_r_q;
      wr_q   <= valid_r_q && wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q <= (valid_r_q && wr_d) ? px_r_q    : '0;
    out_y_q <= (valid_r_q && wr_d) ? py_r_q    : '0;
    color_q <= (valid_r_q && wr_d) ? tex_rdata : '0;
  end

  assign done_o         = done_q;
  assign write_enable_o = wr_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign color_o        = color_q;

endmodule

`default_nettype wire

FILE: src/sspb_checker.sv
// Port-level assertions for the scaled sprite pixel blitter, with its bind.
`default_nettype none

module sspb_checker import sspb_pkg::*; #(
  parameter int TEXEL_WORDS = 4096
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               op_i,
  input wire logic               done_o,
  input wire logic               write_enable_o,
  input wire logic [PIX_W-1:0]   out_x_o,
  input wire logic [PIX_W-1:0]   out_y_o,
  input wire logic [TEXEL_W-1:0] color_o
);

  localparam int LATENCY = PIPE_FIXED + wrap_steps(TEXEL_WORDS);

  // Every request returns one result after the fixed latency
  a_req_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request did not return after the pipe latency");

  // A load never writes the framebuffer
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_LOAD)) |-> ##LATENCY !write_enable_o)
    else $error("load request produced a framebuffer write");

  // A write only comes with a result
  a_write_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> done_o)
    else $error("write enable without result strobe");

  // Transparent texels are never written
  a_write_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> ((color_o[7:0] & ALPHA_MASK) != '0))
    else $error("write of a texel with zero alpha");

  // Fields read zero when nothing is written
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !write_enable_o |-> (out_x_o == '0 && out_y_o == '0 && color_o == '0))
    else $error("non-write result carries non-zero fields");

endmodule

bind scaled_sprite_pixel_blitter sspb_checker #(
  .TEXEL_WORDS (TEXEL_WORDS)
) u_sspb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .done_o         (done_o),
  .write_enable_o (write_enable_o),
  .out_x_o        (out_x_o),
  .out_y_o        (out_y_o),
  .color_o        (color_o)
);

`default_nettype wire
